FILE: rtl/gtm_pkg.sv
`timescale 1ns / 1ps

package gtm_pkg;

	localparam int TILE_COLUMNS_DEF = 768;
	localparam int MAX_ROWS_DEF     = 2048;
	localparam int MAX_COLUMNS_DEF  = 2048;

	localparam int CFG_W    = 12;
	localparam int ROW_W    = 11;
	localparam int COLUMN_W = 11;
	localparam int LOGIT_W  = 16;
	localparam int LABEL_W  = 2;
	localparam int WEIGHT_W = 17;
	localparam int SUM_W    = 36;
	localparam int PROD_W   = LOGIT_W + WEIGHT_W + 1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(32768);
	localparam logic [63:0]         WEIGHT_FLOOR = 64'd3;
	localparam logic [63:0]         Q32_ONE      = 64'h1_0000_0000;

	localparam logic [63:0] EXP_INT_Q32 [5] = '{
		64'd4294967296, 64'd1580030169, 64'd581260615, 64'd213833830, 64'd78665070
	};

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ACC   = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [LABEL_W-1:0] {
		LABEL_ZERO = 2'd0,
		LABEL_ONE  = 2'd1,
		LABEL_TWO  = 2'd2
	} label_t;

	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		sum_t c0;
		sum_t c1;
		sum_t c2;
	} sums_t;

	typedef struct packed {
		prod_t c0;
		prod_t c1;
		prod_t c2;
	} prods_t;

	function automatic sum_t sat_add(input sum_t a, input prod_t p);
		logic signed [SUM_W:0] s;
		s = (SUM_W+1)'(a) + (SUM_W+1)'(p);
		if (s[SUM_W] != s[SUM_W-1])
			return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return s[SUM_W-1:0];
	endfunction

	function automatic label_t argmax3(input sums_t v);
		sum_t   m;
		label_t best;
		m    = v.c0;
		best = LABEL_ZERO;
		if (v.c1 > m) begin
			m    = v.c1;
			best = LABEL_ONE;
		end
		if (v.c2 > m)
			best = LABEL_TWO;
		return best;
	endfunction

endpackage

FILE: rtl/gtm_if.sv
`timescale 1ns / 1ps

interface gtm_in_if import gtm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [1:0]                 op;
	logic [ROW_W-1:0]           row;
	logic [COLUMN_W-1:0]        column;
	logic [COLUMN_W-1:0]        tile_start;
	logic signed [LOGIT_W-1:0]  logit_zero;
	logic signed [LOGIT_W-1:0]  logit_one;
	logic signed [LOGIT_W-1:0]  logit_two;

	modport source (output valid, op, row, column, tile_start, logit_zero, logit_one,
		logit_two, input ready);
	modport sink (input valid, op, row, column, tile_start, logit_zero, logit_one,
		logit_two, output ready);
endinterface

interface gtm_out_if import gtm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] label;

	modport source (output valid, label, input ready);
	modport sink (input valid, label, output ready);
endinterface

FILE: rtl/gaussian_tile_merge_argmax.sv
`timescale 1ns / 1ps
// Gaussian-weighted tile merge with per-pixel argmax.
// in_ch carries one item per transfer: clear a pixel, accumulate three tile
// logits into a pixel, or read a pixel's label. out_ch carries one label per
// read item, in order. cfg_we/cfg_index/cfg_data write image_width (index 0)
// and image_height (index 1); write them only while the block is idle.
// Every item reads a single pixel memory entry holding the three class sums;
// clears and accumulations write it back. One item is taken per cycle while
// in_ch.ready is high. A read's label is pushed into the output queue from
// stage 2 and shown on out_ch once earlier labels are taken. Back-to-back hits
// on one pixel are forwarded from the write stage, so no bubble is needed.
// The Gaussian weight table is a ROM read in the first stage.
// Reset empties the pipeline and output queue and sets the width to 768 and
// height to 2048; pixel memory is not cleared, so clear a pixel before use.
// If out_ch stalls, labels collect in a four-entry queue; in_ch.ready drops
// once queued labels plus items in flight reach four.
module gaussian_tile_merge_argmax import gtm_pkg::*; #(
	parameter int TILE_COLUMNS = TILE_COLUMNS_DEF,
	parameter int MAX_ROWS     = MAX_ROWS_DEF,
	parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	gtm_in_if.sink            in_ch,
	gtm_out_if.source         out_ch,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int MEM_DEPTH  = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int COL_W      = $clog2(MAX_COLUMNS);
	localparam int TIDX_W     = $clog2(TILE_COLUMNS);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);
	localparam logic [63:0] T2   = 64'(TILE_COLUMNS) * 64'(TILE_COLUMNS);
	localparam logic [63:0] TC64 = 64'(TILE_COLUMNS);

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		sums_t             data;
	} wr_t;

	// Gaussian weight ROM
	logic [WEIGHT_W-1:0] rom_tab [TILE_COLUMNS];

	for (genvar gx = 0; gx < TILE_COLUMNS; gx++) begin : g_rom
		localparam logic [63:0] KP  = 64'(2 * gx + 1);
		localparam logic [63:0] KA  = (KP > TC64) ? KP - TC64 : TC64 - KP;
		localparam logic [63:0] A   = ((64'd9 * KA * KA) << 31) / T2;
		localparam logic [63:0] IP  = ((A >> 32) > 64'd4) ? 64'd4 : (A >> 32);
		localparam logic [63:0] F   = A & 64'hFFFF_FFFF;
		localparam logic [63:0] M1  = ((Q32_ONE * F) >> 32) / 64'd1;
		localparam logic [63:0] S1  = Q32_ONE - M1;
		localparam logic [63:0] M2  = ((M1 * F) >> 32) / 64'd2;
		localparam logic [63:0] S2  = S1 + M2;
		localparam logic [63:0] M3  = ((M2 * F) >> 32) / 64'd3;
		localparam logic [63:0] S3  = S2 - M3;
		localparam logic [63:0] M4  = ((M3 * F) >> 32) / 64'd4;
		localparam logic [63:0] S4  = S3 + M4;
		localparam logic [63:0] M5  = ((M4 * F) >> 32) / 64'd5;
		localparam logic [63:0] S5  = S4 - M5;
		localparam logic [63:0] M6  = ((M5 * F) >> 32) / 64'd6;
		localparam logic [63:0] S6  = S5 + M6;
		localparam logic [63:0] M7  = ((M6 * F) >> 32) / 64'd7;
		localparam logic [63:0] S7  = S6 - M7;
		localparam logic [63:0] M8  = ((M7 * F) >> 32) / 64'd8;
		localparam logic [63:0] S8  = S7 + M8;
		localparam logic [63:0] M9  = ((M8 * F) >> 32) / 64'd9;
		localparam logic [63:0] S9  = S8 - M9;
		localparam logic [63:0] M10 = ((M9 * F) >> 32) / 64'd10;
		localparam logic [63:0] S10 = S9 + M10;
		localparam logic [63:0] M11 = ((M10 * F) >> 32) / 64'd11;
		localparam logic [63:0] S11 = S10 - M11;
		localparam logic [63:0] M12 = ((M11 * F) >> 32) / 64'd12;
		localparam logic [63:0] S12 = S11 + M12;
		localparam logic [63:0] SC  = (S12 > Q32_ONE) ? Q32_ONE : S12;
		localparam logic [63:0] R   = (EXP_INT_Q32[IP[2:0]] * SC) >> 32;
		localparam logic [63:0] W   = (R + 64'd65536) >> 17;
		localparam logic [63:0] WL  = (W < WEIGHT_FLOOR) ? WEIGHT_FLOOR : W;
		localparam logic [63:0] WF  = (WL > 64'(WEIGHT_ONE)) ? 64'(WEIGHT_ONE) : WL;
		assign rom_tab[gx] = WF[WEIGHT_W-1:0];
	end

	// Configuration
	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= CFG_W'(768);
			image_height_q <= CFG_W'(2048);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
			endcase
		end
	end

	// Stage 0: decode and issue the memory read
	logic              in_xfer;
	logic              row_ok;
	logic              col_in;
	logic [12:0]       used_w;
	logic              narrow;
	logic [12:0]       pad;
	logic [12:0]       col13;
	logic              narrow_ok;
	logic [12:0]       narrow_pc;
	logic [COLUMN_W:0] wide_pc;
	logic              wide_ok;
	logic [12:0]       acc_pc;
	logic [COL_W-1:0]  mem_col;
	logic [ADDR_W-1:0] addr_s0;
	logic              ok_s0;
	logic [TIDX_W-1:0] rom_idx;
	logic [OUTQ_CW:0]  credit;

	always_comb begin
		row_ok    = ({1'b0, in_ch.row} < image_height_q) && (32'(in_ch.row) < MAX_ROWS);
		col_in    = ({1'b0, in_ch.column} < image_width_q) &&
			(32'(in_ch.column) < MAX_COLUMNS);
		used_w    = (32'(image_width_q) < MAX_COLUMNS) ? {1'b0, image_width_q} :
			13'(MAX_COLUMNS);
		narrow    = 32'(used_w) <= TILE_COLUMNS;
		pad       = (13'(TILE_COLUMNS) - used_w) >> 1;
		col13     = 13'(in_ch.column);
		narrow_ok = (col13 >= pad) && (col13 < pad + used_w);
		narrow_pc = col13 - pad;
		wide_pc   = {1'b0, in_ch.tile_start} + {1'b0, in_ch.column};
		wide_ok   = (32'(in_ch.column) < TILE_COLUMNS) && (13'(wide_pc) < used_w);
		acc_pc    = narrow ? narrow_pc : 13'(wide_pc);
		unique case (in_ch.op)
			OP_ACC: begin
				mem_col = acc_pc[COL_W-1:0];
				ok_s0   = row_ok && (narrow ? narrow_ok : wide_ok);
			end
			OP_CLEAR, OP_READ: begin
				mem_col = COL_W'(in_ch.column);
				ok_s0   = row_ok && col_in;
			end
			default: begin
				mem_col = COL_W'(in_ch.column);
				ok_s0   = 1'b0;
			end
		endcase
		addr_s0 = ADDR_W'(in_ch.row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(mem_col);
		rom_idx = (32'(in_ch.column) < TILE_COLUMNS) ? in_ch.column[TIDX_W-1:0] : '0;
	end

	// Pipeline state
	logic                      v_s1, v_s2;
	logic [1:0]                op_s1, op_s2;
	logic                      ok_s1, ok_s2;
	logic                      narrow_s1;
	logic [ADDR_W-1:0]         addr_s1, addr_s2;
	logic signed [LOGIT_W-1:0] lz_s1, lo_s1, lt_s1;
	logic [WEIGHT_W-1:0]       weight_s1;
	sums_t                     rd_s1;
	sums_t                     base_s2;
	prods_t                    prod_s2;
	wr_t                       wr_q;

	sums_t pix_mem [MEM_DEPTH];

	// Output queue
	logic [LABEL_W-1:0] outq_q [OUTQ_DEPTH];
	logic [OUTQ_PW-1:0] outq_wp_q, outq_rp_q;
	logic [OUTQ_CW-1:0] outq_cnt_q;
	logic               push, pop;

	assign credit      = (OUTQ_CW+1)'(outq_cnt_q) + (OUTQ_CW+1)'(v_s1) + (OUTQ_CW+1)'(v_s2);
	assign in_ch.ready = credit < (OUTQ_CW+1)'(OUTQ_DEPTH);
	assign in_xfer     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk) begin
		rd_s1     <= pix_mem[addr_s0];
		weight_s1 <= rom_tab[rom_idx];
	end

	// Stage 1: forward the previous write and multiply
	sums_t  base_s1;
	prods_t prod_s1;
	logic [WEIGHT_W-1:0] wsel;

	always_comb begin
		base_s1    = (wr_q.valid && wr_q.addr == addr_s1) ? wr_q.data : rd_s1;
		wsel       = narrow_s1 ? WEIGHT_ONE : weight_s1;
		prod_s1.c0 = lz_s1 * signed'({1'b0, wsel});
		prod_s1.c1 = lo_s1 * signed'({1'b0, wsel});
		prod_s1.c2 = lt_s1 * signed'({1'b0, wsel});
	end

	// Stage 2: forward, add or clear, write back, pick the label
	sums_t  old_s2;
	sums_t  new_s2;
	logic   we_s2;
	label_t label_s2;

	always_comb begin
		old_s2 = (wr_q.valid && wr_q.addr == addr_s2) ? wr_q.data : base_s2;
		if (op_s2 == OP_CLEAR) begin
			new_s2 = '0;
		end else begin
			new_s2.c0 = sat_add(old_s2.c0, prod_s2.c0);
			new_s2.c1 = sat_add(old_s2.c1, prod_s2.c1);
			new_s2.c2 = sat_add(old_s2.c2, prod_s2.c2);
		end
		we_s2    = v_s2 && ok_s2 && (op_s2 == OP_CLEAR || op_s2 == OP_ACC);
		label_s2 = ok_s2 ? argmax3(old_s2) : LABEL_ZERO;
		push     = v_s2 && (op_s2 == OP_READ);
	end

	always_ff @(posedge clk) begin
		if (we_s2)
			pix_mem[addr_s2] <= new_s2;
	end

	always_ff @(posedge clk) begin
		op_s1     <= in_ch.op;
		ok_s1     <= ok_s0;
		narrow_s1 <= narrow;
		addr_s1   <= addr_s0;
		lz_s1     <= in_ch.logit_zero;
		lo_s1     <= in_ch.logit_one;
		lt_s1     <= in_ch.logit_two;
		op_s2     <= op_s1;
		ok_s2     <= ok_s1;
		addr_s2   <= addr_s1;
		base_s2   <= base_s1;
		prod_s2   <= prod_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			wr_q <= '0;
		end else begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
			wr_q <= '{valid: we_s2, addr: addr_s2, data: new_s2};
		end
	end

	assign pop          = out_ch.valid && out_ch.ready;
	assign out_ch.valid = outq_cnt_q != '0;
	assign out_ch.label = outq_q[outq_rp_q];

	always_ff @(posedge clk) begin
		if (push)
			outq_q[outq_wp_q] <= label_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outq_wp_q  <= '0;
			outq_rp_q  <= '0;
			outq_cnt_q <= '0;
		end else begin
			if (push)
				outq_wp_q <= outq_wp_q + 1'b1;
			if (pop)
				outq_rp_q <= outq_rp_q + 1'b1;
			outq_cnt_q <= outq_cnt_q + OUTQ_CW'(push) - OUTQ_CW'(pop);
		end
	end

	a_outq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outq_cnt_q <= OUTQ_CW'(OUTQ_DEPTH))
		else $error("output queue count exceeds depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && outq_cnt_q == OUTQ_CW'(OUTQ_DEPTH)))
		else $error("label pushed into a full output queue");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && op_s2 == OP_READ) |=> (outq_cnt_q != '0))
		else $error("read label missing from output queue");

endmodule

FILE: verif/gaussian_tile_merge_argmax_test.sv
`timescale 1ns / 1ps

module gaussian_tile_merge_argmax_test;
	import gtm_pkg::*;

	localparam int TILE = TILE_COLUMNS_DEF;
	localparam int ROWS = MAX_ROWS_DEF;
	localparam int COLS = MAX_COLUMNS_DEF;
	localparam longint SUM_HI = 64'sd34359738367;
	localparam longint SUM_LO = -64'sd34359738368;
	localparam int unsigned UNIT_WEIGHT = 32768;
	localparam int unsigned MIN_WEIGHT = 3;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_CAP = 50;

	typedef struct packed {
		logic [1:0]          op;
		logic [ROW_W-1:0]    row;
		logic [COLUMN_W-1:0] column;
		logic [COLUMN_W-1:0] tile_start;
		logic [LOGIT_W-1:0]  logit_zero;
		logic [LOGIT_W-1:0]  logit_one;
		logic [LOGIT_W-1:0]  logit_two;
	} pixel_cmd_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	gtm_in_if in_ch ();
	gtm_out_if out_ch ();

	gaussian_tile_merge_argmax dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	int unsigned gauss_rom [TILE];
	longint sum_c0 [int];
	longint sum_c1 [int];
	longint sum_c2 [int];
	label_t expected_labels [$];
	int unsigned cfg_width;
	int unsigned cfg_height;
	bit idle_on;
	int items_sent;
	int labels_checked;
	int mismatches;
	int settings_used;
	int quiet_cycles;
	label_t want;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] exp_whole_q32(input logic [63:0] ip);
		case (ip)
		64'd0: return 64'd4294967296;
		64'd1: return 64'd1580030169;
		64'd2: return 64'd581260615;
		64'd3: return 64'd213833830;
		default: return 64'd78665070;
		endcase
	endfunction

	function automatic int unsigned gauss_weight_q15(input int x);
		longint k;
		logic [63:0] k2, a, ip, f, s, term, r, w;
		int n;
		k = 2 * longint'(x) - TILE + 1;
		k2 = k * k;
		a = ((64'd9 * k2) << 31) / (64'(TILE) * 64'(TILE));
		ip = a >> 32;
		f = a & 64'hFFFF_FFFF;
		s = 64'h1_0000_0000;
		term = 64'h1_0000_0000;
		if (ip > 64'd4)
			ip = 64'd4;
		for (n = 1; n <= 12; n++) begin
			term = ((term * f) >> 32) / 64'(n);
			if (n % 2 == 1)
				s = s - term;
			else
				s = s + term;
		end
		if (s > 64'h1_0000_0000)
			s = 64'h1_0000_0000;
		r = (exp_whole_q32(ip) * s) >> 32;
		w = (r + 64'd65536) >> 17;
		if (w < 64'(MIN_WEIGHT))
			w = 64'(MIN_WEIGHT);
		if (w > 64'(UNIT_WEIGHT))
			w = 64'(UNIT_WEIGHT);
		return int'(w);
	endfunction

	function automatic int unsigned used_width();
		return (cfg_width < COLS) ? cfg_width : COLS;
	endfunction

	function automatic int unsigned used_height();
		return (cfg_height < ROWS) ? cfg_height : ROWS;
	endfunction

	function automatic longint clamp_sum(input longint v);
		if (v > SUM_HI)
			return SUM_HI;
		if (v < SUM_LO)
			return SUM_LO;
		return v;
	endfunction

	function automatic int target_pixel(input pixel_cmd_t c);
		int unsigned w, h, pad, pc;
		w = used_width();
		h = used_height();
		if (c.op == OP_UNUSED || c.row >= h)
			return -1;
		if (c.op != OP_ACC)
			return (c.column < w) ? int'(c.row) * COLS + int'(c.column) : -1;
		if (w <= TILE) begin
			pad = (TILE - w) / 2;
			if (c.column < pad || c.column >= pad + w)
				return -1;
			pc = c.column - pad;
		end else begin
			if (c.column >= TILE)
				return -1;
			pc = c.tile_start + c.column;
			if (pc >= w)
				return -1;
		end
		return int'(c.row) * COLS + int'(pc);
	endfunction

	function automatic void merge_predict(input pixel_cmd_t c);
		int key;
		longint wt, a0, a1, a2, best;
		label_t lbl;
		key = target_pixel(c);
		case (c.op)
		OP_CLEAR: if (key >= 0) begin
			sum_c0[key] = 0;
			sum_c1[key] = 0;
			sum_c2[key] = 0;
		end
		OP_ACC: if (key >= 0 && sum_c0.exists(key)) begin
			wt = (used_width() <= TILE) ? UNIT_WEIGHT : gauss_rom[c.column];
			sum_c0[key] = clamp_sum(sum_c0[key] + longint'($signed(c.logit_zero)) * wt);
			sum_c1[key] = clamp_sum(sum_c1[key] + longint'($signed(c.logit_one)) * wt);
			sum_c2[key] = clamp_sum(sum_c2[key] + longint'($signed(c.logit_two)) * wt);
		end
		OP_READ: begin
			lbl = LABEL_ZERO;
			if (key >= 0) begin
				a0 = sum_c0[key];
				a1 = sum_c1[key];
				a2 = sum_c2[key];
				best = a0;
				if (a1 > best) begin
					best = a1;
					lbl = LABEL_ONE;
				end
				if (a2 > best)
					lbl = LABEL_TWO;
			end
			expected_labels.push_back(lbl);
		end
		default: ;
		endcase
	endfunction

	function automatic pixel_cmd_t make_cmd(input logic [1:0] op, input logic [ROW_W-1:0] row,
		input logic [COLUMN_W-1:0] column, input logic [COLUMN_W-1:0] start,
		input logic [LOGIT_W-1:0] l0, input logic [LOGIT_W-1:0] l1,
		input logic [LOGIT_W-1:0] l2);
		pixel_cmd_t c;
		c.op = op;
		c.row = row;
		c.column = column;
		c.tile_start = start;
		c.logit_zero = l0;
		c.logit_one = l1;
		c.logit_two = l2;
		return c;
	endfunction

	function automatic logic [LOGIT_W-1:0] rand_logit();
		case ($urandom_range(0, 5))
		0: return 16'h7FFF;
		1: return 16'h8000;
		2, 3: return LOGIT_W'($urandom_range(0, 1023) - 512);
		default: return LOGIT_W'($urandom);
		endcase
	endfunction

	function automatic pixel_cmd_t noise_cmd();
		return make_cmd(2'($urandom_range(0, 3)), ROW_W'($urandom), COLUMN_W'($urandom),
			COLUMN_W'($urandom), rand_logit(), rand_logit(), rand_logit());
	endfunction

	task automatic transfer_item(input pixel_cmd_t c);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.op         <= c.op;
		in_ch.row        <= c.row;
		in_ch.column     <= c.column;
		in_ch.tile_start <= c.tile_start;
		in_ch.logit_zero <= c.logit_zero;
		in_ch.logit_one  <= c.logit_one;
		in_ch.logit_two  <= c.logit_two;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		merge_predict(c);
		items_sent++;
	endtask

	// clear a pixel the first time it is touched so no undefined entry is read
	task automatic send_item(input pixel_cmd_t c);
		int key;
		pixel_cmd_t wipe;
		key = target_pixel(c);
		if ((c.op == OP_ACC || c.op == OP_READ) && key >= 0 && !sum_c0.exists(key)) begin
			wipe = make_cmd(OP_CLEAR, ROW_W'(key / COLS), COLUMN_W'(key % COLS),
				'0, '0, '0, '0);
			transfer_item(wipe);
		end
		transfer_item(c);
	endtask

	task automatic wait_drained();
		while (expected_labels.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		if (idx == CFG_IMAGE_WIDTH)
			cfg_width = val;
		else
			cfg_height = val;
	endtask

	task automatic configure(input int unsigned w, input int unsigned h);
		in_ch.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic test_directed();
		configure(768, 2048);
		send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(OP_ACC, 0, 0, 11'h7FF, 16'h8000, 16'h7FFF, 16'h7FFF));
		send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(OP_ACC, 2047, 767, 0, 16'h0000, 16'h0000, 16'h0001));
		send_item(make_cmd(OP_ACC, 2047, 768, 0, 16'h7FFF, 16'h0000, 16'h0000));
		send_item(make_cmd(OP_READ, 2047, 768, 0, 0, 0, 0));
		send_item(make_cmd(OP_UNUSED, 2047, 767, 0, 16'h7FFF, 16'h0000, 16'h0000));
		send_item(make_cmd(OP_READ, 2047, 767, 0, 0, 0, 0));
		send_item(make_cmd(OP_CLEAR, 2047, 767, 0, 0, 0, 0));
		send_item(make_cmd(OP_READ, 2047, 767, 0, 0, 0, 0));
		configure(700, 1);
		send_item(make_cmd(OP_ACC, 0, 33, 0, 16'h0000, 16'h0000, 16'h7FFF));
		send_item(make_cmd(OP_ACC, 0, 34, 0, 16'h0000, 16'h0000, 16'h0005));
		send_item(make_cmd(OP_ACC, 0, 733, 0, 16'h0000, 16'h0007, 16'h0000));
		send_item(make_cmd(OP_ACC, 0, 734, 0, 16'h0000, 16'h0000, 16'h7FFF));
		send_item(make_cmd(OP_ACC, 1, 34, 0, 16'h0009, 16'h0000, 16'h0000));
		send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(OP_READ, 0, 699, 0, 0, 0, 0));
		send_item(make_cmd(OP_READ, 1, 0, 0, 0, 0, 0));
		configure(2048, 2048);
		send_item(make_cmd(OP_ACC, 3, 0, 0, 16'h0000, 16'hFF00, 16'h0100));
		send_item(make_cmd(OP_ACC, 3, 767, 1280, 16'h0001, 16'h0002, 16'h0003));
		send_item(make_cmd(OP_ACC, 3, 768, 0, 16'h7FFF, 16'h0000, 16'h0000));
		send_item(make_cmd(OP_ACC, 3, 1, 2047, 16'h7FFF, 16'h0000, 16'h0000));
		send_item(make_cmd(OP_READ, 3, 0, 0, 0, 0, 0));
		send_item(make_cmd(OP_READ, 3, 2047, 0, 0, 0, 0));
	endtask

	task automatic test_saturation();
		int i;
		configure(768, 2048);
		send_item(make_cmd(OP_CLEAR, 5, 5, 0, 0, 0, 0));
		for (i = 0; i < 40; i++) begin
			send_item(make_cmd(OP_ACC, 5, 5, COLUMN_W'($urandom), 16'h7FFE, 16'h8000,
				16'h7FFF));
			if (i == 20)
				send_item(make_cmd(OP_READ, 5, 5, 0, 0, 0, 0));
		end
		send_item(make_cmd(OP_READ, 5, 5, 0, 0, 0, 0));
		send_item(make_cmd(OP_ACC, 5, 5, 0, 16'h8000, 16'h7FFF, 16'h0000));
		send_item(make_cmd(OP_READ, 5, 5, 0, 0, 0, 0));
	endtask

	task automatic merge_sequence();
		int unsigned pr, pc, pad, tcol, n;
		pr = $urandom_range(0, used_height() - 1);
		pc = $urandom_range(0, used_width() - 1);
		n = $urandom_range(1, 6);
		if ($urandom_range(0, 3) != 0)
			send_item(make_cmd(OP_CLEAR, ROW_W'(pr), COLUMN_W'(pc), COLUMN_W'($urandom),
				rand_logit(), rand_logit(), rand_logit()));
		repeat (n) begin
			if (used_width() <= TILE) begin
				pad = (TILE - used_width()) / 2;
				send_item(make_cmd(OP_ACC, ROW_W'(pr), COLUMN_W'(pc + pad),
					COLUMN_W'($urandom), rand_logit(), rand_logit(), rand_logit()));
			end else begin
				tcol = $urandom_range(0, (pc < TILE) ? pc : TILE - 1);
				send_item(make_cmd(OP_ACC, ROW_W'(pr), COLUMN_W'(tcol),
					COLUMN_W'(pc - tcol), rand_logit(), rand_logit(), rand_logit()));
			end
		end
		send_item(make_cmd(OP_READ, ROW_W'(pr), COLUMN_W'(pc), COLUMN_W'($urandom),
			rand_logit(), rand_logit(), rand_logit()));
	endtask

	task automatic test_random_merge(input int unsigned w, input int unsigned h,
		input int count);
		int first;
		configure(w, h);
		first = items_sent;
		while (items_sent - first < count) begin
			if ($urandom_range(0, 3) == 0)
				send_item(noise_cmd());
			else
				merge_sequence();
			if ($urandom_range(0, 40) == 0) begin
				in_ch.valid <= 1'b0;
				wait_drained();
			end
		end
	endtask

	initial begin : sink_pacing
		int stall_left;
		out_ch.ready = 1'b1;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 14);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_labels.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t: label %0d arrived with none expected", $time,
						out_ch.label);
			end else begin
				want = expected_labels.pop_front();
				labels_checked++;
				if (out_ch.label !== want) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: label mismatch, expected %0d actual %0d", $time,
							want, out_ch.label);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d labels outstanding", $time,
				STALL_LIMIT, expected_labels.size());
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int x;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_CLEAR;
		in_ch.row = '0;
		in_ch.column = '0;
		in_ch.tile_start = '0;
		in_ch.logit_zero = '0;
		in_ch.logit_one = '0;
		in_ch.logit_two = '0;
		cfg_width = 768;
		cfg_height = 2048;
		idle_on = 1'b1;
		items_sent = 0;
		labels_checked = 0;
		mismatches = 0;
		settings_used = 0;
		quiet_cycles = 0;
		for (x = 0; x < TILE; x++)
			gauss_rom[x] = gauss_weight_q15(x);
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_saturation();
		test_random_merge(768, 2048, 190);
		test_random_merge(1, 1, 190);
		test_random_merge(2048, 2048, 190);
		test_random_merge(769, 37, 190);
		test_random_merge($urandom_range(2, 767), $urandom_range(1, 2048), 190);
		test_random_merge($urandom_range(770, 2047), $urandom_range(1, 2048), 190);
		idle_on = 1'b0;
		test_random_merge(2048, 2048, 190);

		in_ch.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Sent %0d items under %0d register settings, %0d labels compared.",
			items_sent, settings_used, labels_checked);
		$display("Covered narrow and wide modes, dropped columns, out-of-image reads, "
			, "unused op, saturation and stall bursts.");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
